/* src/sm4e_pkg.sv */
// ----------------------------------------------------------------------------
// SM4 encryption package
// Word type, stage record, S-box table and the round functions shared by the
// pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package sm4e_pkg;

   typedef logic [31:0] word_type;

   // Word 0 of each array is the oldest word of the sliding window.
   typedef struct packed {
      word_type [3:0] data;
      word_type [3:0] key;
   } stage_type;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_HIGH_INDEX = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_LOW_INDEX  = 2'd1;

   localparam word_type FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   function automatic word_type tau(input word_type a);
      return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
   endfunction

   function automatic word_type lin_data(input word_type b);
      return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
               ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
   endfunction

   function automatic word_type lin_key(input word_type b);
      return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
   endfunction

   // Byte j of the constant for round i is (4i+j)*7 mod 256, most significant first.
   function automatic word_type round_const(input int unsigned i);
      word_type c;
      c = '0;
      for (int unsigned j = 0; j < 4; j++) begin
         c = {c[23:0], 8'(((4 * i) + j) * 7)};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* src/sm4e_round.sv */
// ----------------------------------------------------------------------------
// SM4 round stage
// One pipeline stage: one data round with the round key already held in the
// stage, and in parallel the key schedule step that yields the next round key.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4e_round (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       in_valid,
   output logic                      in_ready,
   input  wire sm4e_pkg::stage_type  in_state,
   input  wire sm4e_pkg::word_type   round_const,
   output logic                      out_valid,
   input  wire                       out_ready,
   output sm4e_pkg::stage_type       out_state
);

   logic                valid_ff;
   logic                valid_in;
   sm4e_pkg::stage_type state_ff;
   sm4e_pkg::stage_type state_in;
   sm4e_pkg::word_type  next_data;
   sm4e_pkg::word_type  next_key;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_state = state_ff;

   always_comb begin
      next_data = in_state.data[0] ^ sm4e_pkg::lin_data(sm4e_pkg::tau(
                     in_state.data[1] ^ in_state.data[2] ^ in_state.data[3] ^ in_state.key[3]));
      next_key  = in_state.key[0] ^ sm4e_pkg::lin_key(sm4e_pkg::tau(
                     in_state.key[1] ^ in_state.key[2] ^ in_state.key[3] ^ round_const));
      state_in.data[0] = in_state.data[1];
      state_in.data[1] = in_state.data[2];
      state_in.data[2] = in_state.data[3];
      state_in.data[3] = next_data;
      state_in.key[0]  = in_state.key[1];
      state_in.key[1]  = in_state.key[2];
      state_in.key[2]  = in_state.key[3];
      state_in.key[3]  = next_key;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* src/sm4_block_encrypt.sv */
// An accepted block passes the entry register, then one register per round, before its
// response beat is offered. Throughput: one block per cycle while the response is not
// stalled; an entry stage holding one S-box layer and one linear transform for the key,
// plus one stage per round, each holding the same for data and key.
// Each stage moves on its own, so bubbles close up while the response is stalled.
// Reset clears all stage valid bits and sets both key registers to zero.
// ----------------------------------------------------------------------------
// SM4 block encryption pipeline
// Fully unrolled SM4 encryption with the key schedule carried along with each
// block, so every block uses the key present when it was accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_block_encrypt #(
   parameter int unsigned ROUND_COUNT = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [63:0]                          req_plain_high,
   input  wire  [63:0]                          req_plain_low,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [63:0]                          rsp_cipher_high,
   output logic [63:0]                          rsp_cipher_low,
   input  wire                                  csr_write_enable,
   input  wire  [sm4e_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [63:0]                          csr_write_data
);

   logic [63:0]          key_high_ff;
   logic [63:0]          key_high_in;
   logic [63:0]          key_low_ff;
   logic [63:0]          key_low_in;

   sm4e_pkg::stage_type  entry_in;
   sm4e_pkg::stage_type  entry_ff;
   logic                 entry_valid_ff;
   logic                 entry_valid_in;
   logic                 entry_ready;
   sm4e_pkg::word_type   whitened [4];

   logic                 stage_valid [ROUND_COUNT+1];
   logic                 stage_ready [ROUND_COUNT+1];
   sm4e_pkg::stage_type  stage_state [ROUND_COUNT+1];

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            sm4e_pkg::KEY_HIGH_INDEX: key_high_in = csr_write_data;
            sm4e_pkg::KEY_LOW_INDEX:  key_low_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
      end
   end

   // The entry stage whitens the key and derives the first round key.
   always_comb begin
      whitened[0] = key_high_ff[63:32] ^ sm4e_pkg::FK[0];
      whitened[1] = key_high_ff[31:0]  ^ sm4e_pkg::FK[1];
      whitened[2] = key_low_ff[63:32]  ^ sm4e_pkg::FK[2];
      whitened[3] = key_low_ff[31:0]   ^ sm4e_pkg::FK[3];
      entry_in.data[0] = req_plain_high[63:32];
      entry_in.data[1] = req_plain_high[31:0];
      entry_in.data[2] = req_plain_low[63:32];
      entry_in.data[3] = req_plain_low[31:0];
      entry_in.key[0]  = whitened[1];
      entry_in.key[1]  = whitened[2];
      entry_in.key[2]  = whitened[3];
      entry_in.key[3]  = whitened[0] ^ sm4e_pkg::lin_key(sm4e_pkg::tau(
                            whitened[1] ^ whitened[2] ^ whitened[3]
                            ^ sm4e_pkg::round_const(0)));
   end

   assign entry_ready    = !entry_valid_ff || stage_ready[0];
   assign req_ready      = entry_ready;
   assign entry_valid_in = entry_ready ? req_valid : entry_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_ready && req_valid) begin
         entry_ff <= entry_in;
      end
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_state[0] = entry_ff;
   assign stage_ready[ROUND_COUNT] = rsp_ready;

   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      sm4e_round u_round (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (stage_valid[r]),
         .in_ready    (stage_ready[r]),
         .in_state    (stage_state[r]),
         .round_const (sm4e_pkg::round_const(r + 1)),
         .out_valid   (stage_valid[r+1]),
         .out_ready   (stage_ready[r+1]),
         .out_state   (stage_state[r+1])
      );
   end

   // The four final words leave in reverse order.
   assign rsp_valid       = stage_valid[ROUND_COUNT];
   assign rsp_cipher_high = {stage_state[ROUND_COUNT].data[3], stage_state[ROUND_COUNT].data[2]};
   assign rsp_cipher_low  = {stage_state[ROUND_COUNT].data[1], stage_state[ROUND_COUNT].data[0]};

endmodule

`default_nettype wire

/* sim/sm4_block_encrypt_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SM4 block encryption scoreboard
// Computes the expected ciphertext of every accepted plaintext beat under the
// key held at acceptance, and compares the response beats in order.
// ----------------------------------------------------------------------------

package sm4_block_encrypt_tb_pkg;

   typedef logic [31:0] word_type;
   typedef logic [sm4e_pkg::CSR_INDEX_WIDTH-1:0] csr_index_type;

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } cipher_block_type;

   localparam logic [7:0] SUB_BYTE [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   localparam word_type KEY_WHITEN [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197,
                                           32'hb27022dc};
   localparam int unsigned NUM_ROUNDS = 32;

   class cipher_scoreboard;
      logic [63:0]      key_high;
      logic [63:0]      key_low;
      cipher_block_type expected_cipher [$];
      int               error_count;

      function new();
         key_high = '0;
         key_low = '0;
         error_count = 0;
      endfunction

      function void load_key(input csr_index_type index, input logic [63:0] value);
         if (index == sm4e_pkg::KEY_HIGH_INDEX) begin
            key_high = value;
         end else if (index == sm4e_pkg::KEY_LOW_INDEX) begin
            key_low = value;
         end
      endfunction

      function int pending();
         return expected_cipher.size();
      endfunction

      function word_type rotate_left(input word_type w, input int unsigned n);
         return (w << n) | (w >> (32 - n));
      endfunction

      function word_type sub_word(input word_type a);
         word_type s;
         for (int i = 0; i < 4; i++) begin
            s[8*i +: 8] = SUB_BYTE[a[8*i +: 8]];
         end
         return s;
      endfunction

      function word_type diffuse_data(input word_type b);
         return b ^ rotate_left(b, 2) ^ rotate_left(b, 10) ^ rotate_left(b, 18)
                  ^ rotate_left(b, 24);
      endfunction

      function word_type diffuse_key(input word_type b);
         return b ^ rotate_left(b, 13) ^ rotate_left(b, 23);
      endfunction

      function word_type round_constant(input int unsigned r);
         word_type c;
         c = '0;
         for (int unsigned j = 0; j < 4; j++) begin
            c = (c << 8) | word_type'(((4 * r + j) * 7) % 256);
         end
         return c;
      endfunction

      function cipher_block_type encrypt(input logic [63:0] plain_high,
                                         input logic [63:0] plain_low);
         word_type         key_win [4];
         word_type         data_win [4];
         word_type         round_key;
         word_type         next_data;
         cipher_block_type result;
         key_win[0] = key_high[63:32] ^ KEY_WHITEN[0];
         key_win[1] = key_high[31:0] ^ KEY_WHITEN[1];
         key_win[2] = key_low[63:32] ^ KEY_WHITEN[2];
         key_win[3] = key_low[31:0] ^ KEY_WHITEN[3];
         data_win[0] = plain_high[63:32];
         data_win[1] = plain_high[31:0];
         data_win[2] = plain_low[63:32];
         data_win[3] = plain_low[31:0];
         for (int unsigned r = 0; r < NUM_ROUNDS; r++) begin
            round_key = key_win[0] ^ diffuse_key(sub_word(key_win[1] ^ key_win[2] ^ key_win[3]
                                                          ^ round_constant(r)));
            next_data = data_win[0] ^ diffuse_data(sub_word(data_win[1] ^ data_win[2]
                                                            ^ data_win[3] ^ round_key));
            for (int i = 0; i < 3; i++) begin
               key_win[i] = key_win[i+1];
               data_win[i] = data_win[i+1];
            end
            key_win[3] = round_key;
            data_win[3] = next_data;
         end
         result.high = {data_win[3], data_win[2]};
         result.low = {data_win[1], data_win[0]};
         return result;
      endfunction

      function void note_block(input logic [63:0] plain_high, input logic [63:0] plain_low);
         expected_cipher.push_back(encrypt(plain_high, plain_low));
      endfunction

      function void check_block(input logic [63:0] cipher_high, input logic [63:0] cipher_low);
         cipher_block_type expected;
         if (expected_cipher.size() == 0) begin
            $error("response beat with no block outstanding: %h %h", cipher_high, cipher_low);
            error_count++;
            return;
         end
         expected = expected_cipher.pop_front();
         if (cipher_high !== expected.high) begin
            $error("cipher_high mismatch: expected %h, got %h", expected.high, cipher_high);
            error_count++;
         end
         if (cipher_low !== expected.low) begin
            $error("cipher_low mismatch: expected %h, got %h", expected.low, cipher_low);
            error_count++;
         end
      endfunction
   endclass

endpackage

/* sim/sm4_block_encrypt_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SM4 block encryption testbench
// Drives plaintext beats with random gaps and random response stalls, changes
// the key between drained phases, and checks every ciphertext beat in order.
// ----------------------------------------------------------------------------

module sm4_block_encrypt_tb;

   localparam sm4_block_encrypt_tb_pkg::csr_index_type SPARE_INDEX_A = 2'd2;
   localparam sm4_block_encrypt_tb_pkg::csr_index_type SPARE_INDEX_B = 2'd3;
   localparam int         NUM_PHASES = 8;
   localparam int         BLOCKS_PER_PHASE = 168;
   localparam int         SETTLE_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire         req_ready;
   logic [63:0] req_plain_high = '0;
   logic [63:0] req_plain_low = '0;
   wire         rsp_valid;
   logic        rsp_ready = 1'b0;
   wire  [63:0] rsp_cipher_high;
   wire  [63:0] rsp_cipher_low;
   logic        csr_write_enable = 1'b0;
   sm4_block_encrypt_tb_pkg::csr_index_type csr_index = '0;
   logic [63:0] csr_write_data = '0;

   bit                                        full_speed = 1'b0;
   int                                        ready_hold = 0;
   sm4_block_encrypt_tb_pkg::cipher_scoreboard cipher_sb = new();

   sm4_block_encrypt u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_plain_high  (req_plain_high),
      .req_plain_low   (req_plain_low),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cipher_high (rsp_cipher_high),
      .rsp_cipher_low  (rsp_cipher_low),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #10ms;
      $display("sm4_block_encrypt_tb: errors");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] random_half();
      int r;
      r = $urandom_range(0, 15);
      case (r)
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2: begin
            return 64'd1 << $urandom_range(0, 63);
         end
         default: begin
            return {$urandom(), $urandom()};
         end
      endcase
   endfunction

   // Response side: random stalls, and a settled ready in full-speed phases.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            cipher_sb.check_block(rsp_cipher_high, rsp_cipher_low);
         end
         if (full_speed) begin
            rsp_ready <= 1'b1;
         end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            ready_hold = pick_gap();
         end else begin
            rsp_ready <= 1'b1;
            ready_hold = $urandom_range(0, 6);
         end
      end
   end

   task automatic send_block(input logic [63:0] plain_high, input logic [63:0] plain_low,
                             input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_plain_high <= plain_high;
      req_plain_low <= plain_low;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cipher_sb.note_block(plain_high, plain_low);
   endtask

   task automatic drain_blocks();
      req_valid <= 1'b0;
      while (cipher_sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input sm4_block_encrypt_tb_pkg::csr_index_type index,
                            input logic [63:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      cipher_sb.load_key(index, value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int phase;
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The key is still at its reset value of zero here.
      send_block('0, '0, pick_gap());
      send_block('1, '1, pick_gap());
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, pick_gap());
      drain_blocks();

      write_csr(sm4e_pkg::KEY_HIGH_INDEX, 64'h0123456789abcdef);
      write_csr(sm4e_pkg::KEY_LOW_INDEX, 64'hfedcba9876543210);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, pick_gap());
      send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, pick_gap());
      send_block('0, '1, pick_gap());
      send_block('1, '0, pick_gap());
      send_block(64'h8000000000000000, 64'h0000000000000001, pick_gap());
      drain_blocks();

      // Writes to unused indexes must leave the key untouched.
      write_csr(SPARE_INDEX_A, {$urandom(), $urandom()});
      write_csr(SPARE_INDEX_B, {$urandom(), $urandom()});
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, pick_gap());
      drain_blocks();

      write_csr(sm4e_pkg::KEY_HIGH_INDEX, '1);
      write_csr(sm4e_pkg::KEY_LOW_INDEX, '1);
      send_block('0, '0, pick_gap());
      send_block('1, '1, pick_gap());
      drain_blocks();

      write_csr(sm4e_pkg::KEY_HIGH_INDEX, '0);
      send_block('0, '0, pick_gap());
      send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, pick_gap());

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_blocks();
         full_speed = 1'b0;
         case (phase)
            0: begin
               write_csr(sm4e_pkg::KEY_HIGH_INDEX, '0);
               write_csr(sm4e_pkg::KEY_LOW_INDEX, '0);
            end
            1: begin
               write_csr(sm4e_pkg::KEY_HIGH_INDEX, '1);
               write_csr(sm4e_pkg::KEY_LOW_INDEX, '1);
            end
            2: begin
               write_csr(sm4e_pkg::KEY_HIGH_INDEX, {$urandom(), $urandom()});
            end
            3: begin
               write_csr(sm4e_pkg::KEY_LOW_INDEX, {$urandom(), $urandom()});
               write_csr(SPARE_INDEX_A, {$urandom(), $urandom()});
            end
            default: begin
               write_csr(sm4e_pkg::KEY_HIGH_INDEX, random_half());
               write_csr(sm4e_pkg::KEY_LOW_INDEX, random_half());
               write_csr(SPARE_INDEX_B, {$urandom(), $urandom()});
            end
         endcase
         full_speed = (phase == 2) || (phase == 5);
         for (n = 0; n < BLOCKS_PER_PHASE; n++) begin
            send_block(random_half(), random_half(), full_speed ? 0 : pick_gap());
         end
      end

      drain_blocks();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (cipher_sb.error_count == 0 && cipher_sb.pending() == 0) begin
         $display("sm4_block_encrypt_tb: clean");
      end else begin
         $display("sm4_block_encrypt_tb: errors");
      end
      $finish;
   end

endmodule
